// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CBD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define CBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cbd_pkg.sv =====
// Package: widths, result type and the minimum-power ROM.
`timescale 1ns / 1ps
`default_nettype none

package cbd_pkg;

  localparam int STEPS_DEFAULT = 22;
  localparam int STEPS_MAX     = 26;
  localparam int RESIDUE_W     = 22;
  localparam int ODD_W         = 5;
  localparam int AFF_W         = 57;
  localparam int HEIGHT_W      = 6;
  localparam int OFFSET_W      = 6;
  localparam int QMIN_ENTRIES  = 90;
  localparam int QIDX_W        = 7;
  localparam int T_W           = 8;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 6'd61;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = 6'd57;

  typedef struct packed {
    logic [ODD_W-1:0]    odd_steps;
    logic [AFF_W-1:0]    affine_constant;
    logic [HEIGHT_W-1:0] height;
  } res_t;

  // qmin[k] = least q with 3^q >= 2^k
  localparam logic [HEIGHT_W-1:0] QMIN_ROM [QMIN_ENTRIES] = '{
    6'd0,  6'd1,  6'd2,  6'd2,  6'd3,  6'd4,  6'd4,  6'd5,  6'd6,  6'd6,
    6'd7,  6'd7,  6'd8,  6'd9,  6'd9,  6'd10, 6'd11, 6'd11, 6'd12, 6'd12,
    6'd13, 6'd14, 6'd14, 6'd15, 6'd16, 6'd16, 6'd17, 6'd18, 6'd18, 6'd19,
    6'd19, 6'd20, 6'd21, 6'd21, 6'd22, 6'd23, 6'd23, 6'd24, 6'd24, 6'd25,
    6'd26, 6'd26, 6'd27, 6'd28, 6'd28, 6'd29, 6'd30, 6'd30, 6'd31, 6'd31,
    6'd32, 6'd33, 6'd33, 6'd34, 6'd35, 6'd35, 6'd36, 6'd36, 6'd37, 6'd38,
    6'd38, 6'd39, 6'd40, 6'd40, 6'd41, 6'd42, 6'd42, 6'd43, 6'd43, 6'd44,
    6'd45, 6'd45, 6'd46, 6'd47, 6'd47, 6'd48, 6'd48, 6'd49, 6'd50, 6'd50,
    6'd51, 6'd52, 6'd52, 6'd53, 6'd53, 6'd54, 6'd55, 6'd55, 6'd56, 6'd57
  };

  // Indexes past the table end read the last entry.
  function automatic logic [HEIGHT_W-1:0] qmin(input logic [QIDX_W-1:0] k);
    if (k >= QIDX_W'(QMIN_ENTRIES - 1)) begin
      return QMIN_ROM[QMIN_ENTRIES-1];
    end
    return QMIN_ROM[k];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cbd_if.sv =====
// Valid/ready channel interfaces: residue in, descriptor out, config write.
`timescale 1ns / 1ps
`default_nettype none

interface cbd_in_if;
  logic                           valid;
  logic                           ready;
  logic [cbd_pkg::RESIDUE_W-1:0]  residue;

  modport source (output valid, output residue, input ready);
  modport sink   (input valid, input residue, output ready);
endinterface

interface cbd_out_if;
  logic                           valid;
  logic                           ready;
  logic [cbd_pkg::ODD_W-1:0]      odd_steps;
  logic [cbd_pkg::AFF_W-1:0]      affine_constant;
  logic [cbd_pkg::HEIGHT_W-1:0]   height;

  modport source (output valid, output odd_steps, output affine_constant,
                  output height, input ready);
  modport sink   (input valid, input odd_steps, input affine_constant,
                  input height, output ready);
endinterface

interface cbd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cbd_pkg::OFFSET_W-1:0]   height_offset;

  modport source (output valid, output height_offset, input ready);
  modport sink   (input valid, input height_offset, output ready);
endinterface

`default_nettype wire

// ===== rtl/cbd_cell.sv =====
// One step of the shortcut map, registered; cells are chained one per step.
`timescale 1ns / 1ps
`default_nettype none

module cbd_cell #(
  parameter int NW = 22,
  parameter int J  = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [NW-1:0]                 n_i,
  input  cbd_pkg::res_t                 acc_i,
  input  logic [cbd_pkg::OFFSET_W-1:0]  offset_i,
  output logic                          valid_o,
  output logic [NW-1:0]                 n_o,
  output cbd_pkg::res_t                 acc_o
);
  import cbd_pkg::*;

  localparam logic [AFF_W-1:0] POW2 = AFF_W'(64'd1 << (J - 1));

  logic                    odd;
  logic [NW+1:0]           n3;
  logic [NW-1:0]           n_d;
  res_t                    acc_d;
  logic [QIDX_W-1:0]       qidx;
  logic signed [T_W-1:0]   t;

  logic                    valid_q;
  logic [NW-1:0]           n_q;
  res_t                    acc_q;

  always_comb begin
    odd  = n_i[0];
    // only low bits matter for later parities, so n stays NW wide
    n3   = {2'b00, n_i} + {1'b0, n_i, 1'b0} + (NW+2)'(1);
    n_d  = odd ? n3[NW:1] : (n_i >> 1);

    acc_d.affine_constant = odd
      ? (acc_i.affine_constant + {acc_i.affine_constant[AFF_W-2:0], 1'b0} + POW2)
      : acc_i.affine_constant;
    acc_d.odd_steps = acc_i.odd_steps + ODD_W'(odd);

    qidx = QIDX_W'(offset_i) + QIDX_W'(J);
    t    = $signed({2'b00, qmin(qidx)}) - $signed({3'b000, acc_d.odd_steps});
    // first step's term is never negative, so a zero start is safe
    acc_d.height = (t > $signed({2'b00, acc_i.height})) ? t[HEIGHT_W-1:0]
                                                        : acc_i.height;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      n_q   <= n_d;
      acc_q <= acc_d;
    end
  end

  assign valid_o = valid_q;
  assign n_o     = n_q;
  assign acc_o   = acc_q;

endmodule

`default_nettype wire

// ===== rtl/cbd_skid.sv =====
// Output register with skid stage; upstream ready depends on registers only.
`timescale 1ns / 1ps
`default_nettype none

module cbd_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  cbd_pkg::res_t  data_i,
  output logic           ready_o,
  cbd_out_if.source      out_o
);
  import cbd_pkg::*;

  logic  out_v_q, out_v_d;
  res_t  out_q, out_d;
  logic  skid_v_q, skid_v_d;
  res_t  skid_q, skid_d;
  logic  take;
  logic  drain;

  always_comb begin
    ready_o  = ~skid_v_q;
    take     = valid_i & ready_o;
    drain    = ~out_v_q | out_o.ready;
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (drain) begin
      if (skid_v_q) begin
        out_v_d  = 1'b1;
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end else begin
        out_v_d = take;
        out_d   = data_i;
      end
    end else if (take) begin
      skid_v_d = 1'b1;
      skid_d   = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_o.valid           = out_v_q;
  assign out_o.odd_steps       = out_q.odd_steps;
  assign out_o.affine_constant = out_q.affine_constant;
  assign out_o.height          = out_q.height;

endmodule

`default_nettype wire

// ===== rtl/collatz_block_descriptor_core.sv =====
// Top level: shortcut-Collatz residue descriptor, one cell per step.
// Takes one residue beat per clock unless the chain is stalled and returns
// one descriptor beat per residue: odd-step count s, affine constant c
// (2^STEPS * n_final = 3^s * u + c) and height h. A chain of STEPS cells
// does one map step each; a result passes through the STEPS cell registers
// and then the output register. A two-entry output buffer lets the chain
// keep moving while its skid entry is free; it stops only when both
// entries are full. height_offset (reset 61) must be written only while
// no beat is in flight; the config port is always ready.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module collatz_block_descriptor_core #(
  parameter int STEPS = cbd_pkg::STEPS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cbd_cfg_if.sink     cfg_i,
  cbd_in_if.sink      in_i,
  cbd_out_if.source   out_o
);
  import cbd_pkg::*;

  logic [OFFSET_W-1:0] offset_q;
  logic                chain_en;

  logic            v_w   [STEPS+1];
  logic [STEPS-1:0] n_w  [STEPS+1];
  res_t            acc_w [STEPS+1];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OFFSET_RESET;
    end else if (cfg_i.valid) begin
      offset_q <= cfg_i.height_offset;
    end
  end

  assign in_i.ready = chain_en;
  assign v_w[0]     = in_i.valid;
  assign n_w[0]     = STEPS'(in_i.residue);
  assign acc_w[0]   = '0;

  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    cbd_cell #(
      .NW (STEPS),
      .J  (g + 1)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (chain_en),
      .valid_i  (v_w[g]),
      .n_i      (n_w[g]),
      .acc_i    (acc_w[g]),
      .offset_i (offset_q),
      .valid_o  (v_w[g+1]),
      .n_o      (n_w[g+1]),
      .acc_o    (acc_w[g+1])
    );
  end

  cbd_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_w[STEPS]),
    .data_i  (acc_w[STEPS]),
    .ready_o (chain_en),
    .out_o   (out_o)
  );

  // a full skid entry implies the output register is also full
  `CBD_ASSERT(a_skid_behind_out, clk_i, rst_ni, chain_en || out_o.valid,
    "skid entry held with empty output register")
  `CBD_ASSERT_NEXT(a_first_cell_loads, clk_i, rst_ni, in_i.valid && in_i.ready,
    v_w[1], "accepted residue did not reach first cell")
  `CBD_ASSERT(a_odd_bound, clk_i, rst_ni,
    !out_o.valid || (32'(out_o.odd_steps) <= STEPS), "odd count above step count")
  `CBD_ASSERT(a_height_bound, clk_i, rst_ni,
    !out_o.valid || (out_o.height <= HEIGHT_MAX), "height above table maximum")

endmodule

`default_nettype wire
